### hdl/arx_pkg.sv
`timescale 1ns / 1ps

package arx_pkg;

  // Sizing of the controller.
  localparam int MAX_OUTPUTS = 8;
  localparam int MAX_INPUTS  = 8;
  localparam int MAX_ORDER_A = 8;
  localparam int MAX_ORDER_B = 8;

  // The coefficient address format reserves three bits each for row, block and column.
  localparam int ADDR_SPAN  = 8;
  localparam int COEF_DEPTH = 1024;
  localparam int COEF_AW    = 10;

  localparam int HIST_OUT_DEPTH = MAX_ORDER_A * MAX_OUTPUTS;
  localparam int HIST_IN_DEPTH  = MAX_ORDER_B * MAX_INPUTS;
  localparam int HIST_OUT_AW    = (HIST_OUT_DEPTH > 1) ? $clog2(HIST_OUT_DEPTH) : 1;
  localparam int HIST_IN_AW     = (HIST_IN_DEPTH > 1) ? $clog2(HIST_IN_DEPTH) : 1;
  localparam int STG_OUT_W      = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int STG_IN_W       = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  // Field widths.
  localparam int IDX_W      = 10;
  localparam int SMP_W      = 32;
  localparam int ACC_W      = 64;
  localparam int CNT_W      = 4;
  localparam int SEL_W      = 3;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 32;

  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [SEL_W-1:0]       sel_t;
  typedef logic [COEF_AW-1:0]     coef_addr_t;
  typedef logic [HIST_OUT_AW-1:0] hist_out_addr_t;
  typedef logic [HIST_IN_AW-1:0]  hist_in_addr_t;
  typedef logic [STG_OUT_W-1:0]   stg_out_idx_t;
  typedef logic [STG_IN_W-1:0]    stg_in_idx_t;
  typedef logic [IDX_W-1:0]       idx_t;

  // Largest counts that actually take effect.
  localparam cnt_t EFF_OUT_MAX = cnt_t'((MAX_OUTPUTS < ADDR_SPAN) ? MAX_OUTPUTS : ADDR_SPAN);
  localparam cnt_t EFF_IN_MAX  = cnt_t'((MAX_INPUTS < ADDR_SPAN) ? MAX_INPUTS : ADDR_SPAN);
  localparam cnt_t EFF_A_MAX   = cnt_t'((MAX_ORDER_A < ADDR_SPAN) ? MAX_ORDER_A : ADDR_SPAN);
  localparam cnt_t EFF_B_MAX   = cnt_t'((MAX_ORDER_B < ADDR_SPAN) ? MAX_ORDER_B : ADDR_SPAN);

  // Item modes.
  localparam logic [1:0] MODE_COEF   = 2'd0;
  localparam logic [1:0] MODE_OUTPUT = 2'd1;
  localparam logic [1:0] MODE_INPUT  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_NUM_OUTPUTS = 2'd0;
  localparam logic [1:0] REG_NUM_INPUTS  = 2'd1;
  localparam logic [1:0] REG_ORDER_A     = 2'd2;
  localparam logic [1:0] REG_ORDER_B     = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMMIT,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } arx_state_e;

  // Effective configuration.
  typedef struct packed {
    cnt_t no;
    cnt_t ni;
    cnt_t pa;
    cnt_t pb;
  } arx_cfg_t;

  // Sequencer commands to the datapath.
  typedef struct packed {
    logic           in_ready;
    logic           clr;
    coef_addr_t     clr_addr;
    logic           cmt_we_out;
    logic           cmt_we_in;
    hist_out_addr_t cmt_out_addr;
    hist_in_addr_t  cmt_in_addr;
    sel_t           cmt_idx;
    logic           rd_en;
    logic           rd_beta;
    coef_addr_t     coef_raddr;
    hist_out_addr_t out_raddr;
    hist_in_addr_t  in_raddr;
    logic           acc_clear;
    logic           emit;
    sel_t           emit_chan;
    logic           emit_last;
  } arx_ctrl_t;

  function automatic cnt_t eff_count(input cnt_t v, input cnt_t maxv);
    if (v == '0) begin
      return cnt_t'(1);
    end
    if (v > maxv) begin
      return maxv;
    end
    return v;
  endfunction

  // Move the newest slot one place back, wrapping to the oldest slot of the order.
  function automatic sel_t step_back(input sel_t slot, input cnt_t order);
    if (slot == '0 || {1'b0, slot} >= order) begin
      return sel_t'(order - cnt_t'(1));
    end
    return slot - sel_t'(1);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      return a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

  // Q24.40 to Q16.16: shift by 24, round half up, saturate to 32 bits.
  function automatic logic signed [SMP_W-1:0] to_q16(input logic signed [ACC_W-1:0] acc);
    logic [40:0] q;
    q = {acc[63], acc[63:24]} + {40'd0, acc[23]};
    if (q[40:31] != {10{q[40]}}) begin
      return q[40] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end
    return q[31:0];
  endfunction

endpackage

### hdl/arx_ram.sv
`timescale 1ns / 1ps

module arx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/arx_mac.sv
`timescale 1ns / 1ps

module arx_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                issue_i,
  input  logic                                beta_i,
  input  logic                                acc_clear_i,
  input  logic signed [arx_pkg::SMP_W-1:0]    coef_i,
  input  logic signed [arx_pkg::SMP_W-1:0]    out_smp_i,
  input  logic signed [arx_pkg::SMP_W-1:0]    in_smp_i,
  output logic signed [arx_pkg::ACC_W-1:0]    acc_o,
  output logic                                busy_o
);

  // Stage 1: memory data valid. Stage 2: product valid.
  logic                             v1_q, beta1_q, v2_q;
  logic signed [arx_pkg::SMP_W-1:0] sample;
  logic signed [arx_pkg::ACC_W-1:0] prod_d, prod_q;
  logic signed [arx_pkg::ACC_W-1:0] acc_d, acc_q;

  assign sample = beta1_q ? in_smp_i : out_smp_i;
  assign prod_d = coef_i * sample;

  always_comb begin
    acc_d = acc_q;
    if (acc_clear_i) begin
      acc_d = '0;
    end else if (v2_q) begin
      acc_d = arx_pkg::sat_add(acc_q, prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      beta1_q <= 1'b0;
      v2_q    <= 1'b0;
      acc_q   <= '0;
    end else begin
      v1_q    <= issue_i;
      beta1_q <= beta_i;
      v2_q    <= v1_q;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = v1_q | v2_q;

endmodule

### hdl/arx_seq.sv
`timescale 1ns / 1ps

module arx_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arx_pkg::arx_cfg_t   cfg_i,
  input  logic                commit_i,
  input  logic                mac_busy_i,
  input  logic                out_free_i,
  output arx_pkg::arx_ctrl_t  ctrl_o
);

  arx_pkg::arx_state_e state_d, state_q;
  arx_pkg::coef_addr_t clr_d, clr_q;
  arx_pkg::sel_t       cj_d, cj_q;
  arx_pkg::sel_t       i_d, i_q, k_d, k_q, j_d, j_q, slot_d, slot_q;
  logic                beta_d, beta_q;
  arx_pkg::sel_t       nout_d, nout_q, nin_d, nin_q;

  arx_pkg::cnt_t cmt_len, last_j, order;
  logic          j_end, k_end, slot_wrap;

  always_comb begin
    cmt_len   = (cfg_i.no > cfg_i.ni) ? cfg_i.no : cfg_i.ni;
    last_j    = beta_q ? cfg_i.ni : cfg_i.no;
    order     = beta_q ? cfg_i.pb : cfg_i.pa;
    j_end     = ({1'b0, j_q} + arx_pkg::cnt_t'(1)) == last_j;
    k_end     = ({1'b0, k_q} + arx_pkg::cnt_t'(1)) == order;
    slot_wrap = ({1'b0, slot_q} + arx_pkg::cnt_t'(1)) == order;
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cj_d    = cj_q;
    i_d     = i_q;
    k_d     = k_q;
    j_d     = j_q;
    slot_d  = slot_q;
    beta_d  = beta_q;
    nout_d  = nout_q;
    nin_d   = nin_q;

    ctrl_o              = '0;
    ctrl_o.clr_addr     = clr_q;
    ctrl_o.cmt_idx      = cj_q;
    ctrl_o.cmt_out_addr = arx_pkg::hist_out_addr_t'(nout_q)
                          * arx_pkg::hist_out_addr_t'(arx_pkg::MAX_OUTPUTS)
                          + arx_pkg::hist_out_addr_t'(cj_q);
    ctrl_o.cmt_in_addr  = arx_pkg::hist_in_addr_t'(nin_q)
                          * arx_pkg::hist_in_addr_t'(arx_pkg::MAX_INPUTS)
                          + arx_pkg::hist_in_addr_t'(cj_q);
    ctrl_o.rd_beta      = beta_q;
    ctrl_o.coef_raddr   = {beta_q, i_q, k_q, j_q};
    ctrl_o.out_raddr    = arx_pkg::hist_out_addr_t'(slot_q)
                          * arx_pkg::hist_out_addr_t'(arx_pkg::MAX_OUTPUTS)
                          + arx_pkg::hist_out_addr_t'(j_q);
    ctrl_o.in_raddr     = arx_pkg::hist_in_addr_t'(slot_q)
                          * arx_pkg::hist_in_addr_t'(arx_pkg::MAX_INPUTS)
                          + arx_pkg::hist_in_addr_t'(j_q);
    ctrl_o.emit_chan    = i_q;
    ctrl_o.emit_last    = ({1'b0, i_q} + arx_pkg::cnt_t'(1)) == cfg_i.ni;

    case (state_q)
      arx_pkg::ST_CLEAR: begin
        ctrl_o.clr = 1'b1;
        clr_d      = clr_q + arx_pkg::coef_addr_t'(1);
        if (clr_q == '1) begin
          state_d = arx_pkg::ST_IDLE;
        end
      end
      arx_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (commit_i) begin
          nout_d  = arx_pkg::step_back(nout_q, cfg_i.pa);
          nin_d   = arx_pkg::step_back(nin_q, cfg_i.pb);
          cj_d    = '0;
          state_d = arx_pkg::ST_COMMIT;
        end
      end
      arx_pkg::ST_COMMIT: begin
        ctrl_o.cmt_we_out = {1'b0, cj_q} < cfg_i.no;
        ctrl_o.cmt_we_in  = {1'b0, cj_q} < cfg_i.ni;
        ctrl_o.acc_clear  = 1'b1;
        cj_d              = cj_q + arx_pkg::sel_t'(1);
        if (({1'b0, cj_q} + arx_pkg::cnt_t'(1)) == cmt_len) begin
          i_d     = '0;
          k_d     = '0;
          j_d     = '0;
          beta_d  = 1'b0;
          slot_d  = nout_q;
          state_d = arx_pkg::ST_ISSUE;
        end
      end
      arx_pkg::ST_ISSUE: begin
        ctrl_o.rd_en = 1'b1;
        if (j_end) begin
          j_d = '0;
          if (k_end) begin
            if (!beta_q) begin
              beta_d = 1'b1;
              k_d    = '0;
              slot_d = nin_q;
            end else begin
              state_d = arx_pkg::ST_DRAIN;
            end
          end else begin
            k_d    = k_q + arx_pkg::sel_t'(1);
            slot_d = slot_wrap ? '0 : slot_q + arx_pkg::sel_t'(1);
          end
        end else begin
          j_d = j_q + arx_pkg::sel_t'(1);
        end
      end
      arx_pkg::ST_DRAIN: begin
        if (!mac_busy_i) begin
          state_d = arx_pkg::ST_EMIT;
        end
      end
      arx_pkg::ST_EMIT: begin
        if (out_free_i) begin
          ctrl_o.emit      = 1'b1;
          ctrl_o.acc_clear = 1'b1;
          if (ctrl_o.emit_last) begin
            state_d = arx_pkg::ST_IDLE;
          end else begin
            i_d     = i_q + arx_pkg::sel_t'(1);
            k_d     = '0;
            j_d     = '0;
            beta_d  = 1'b0;
            slot_d  = nout_q;
            state_d = arx_pkg::ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = arx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arx_pkg::ST_CLEAR;
      clr_q   <= '0;
      cj_q    <= '0;
      i_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      slot_q  <= '0;
      beta_q  <= 1'b0;
      nout_q  <= '0;
      nin_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cj_q    <= cj_d;
      i_q     <= i_d;
      k_q     <= k_d;
      j_q     <= j_d;
      slot_q  <= slot_d;
      beta_q  <= beta_d;
      nout_q  <= nout_d;
      nin_q   <= nin_d;
    end
  end

endmodule

### hdl/mimo_arx_controller.sv
`timescale 1ns / 1ps

// Channel     | Direction | Transaction contents
// s_axis      | in        | tdata: index[9:0], sample_value[41:10]; tuser: mode; tlast: last
// m_axis      | out       | tdata: control_value[31:0]; tuser: channel; tlast: last_of_run
// cfg         | in        | write of register cfg_idx_i with cfg_wdata_i, no wait
//
// Coefficient writes, staged elements and input elements without the last flag are taken
// when idle and may follow back to back. A last input element starts the history commit
// over max(no, ni) channels, then ni sums on the single multiply-accumulate unit, which
// takes one term per cycle and drains its two-stage pipeline before each result load.
// After reset a clearing pass over 1024 addresses zeroes the coefficient store and both
// histories; s_axis_tready stays low during it, configuration writes are taken. A stalled
// result port holds the sequencer only when the next result is ready.

module mimo_arx_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [arx_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // index[9:0], sample_value[41:10]
  input  logic [1:0]                        s_axis_tuser,   // mode[1:0]
  input  logic                              s_axis_tlast,
  // Result items.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [arx_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // control_value[31:0]
  output logic [arx_pkg::SEL_W-1:0]         m_axis_tuser,   // channel[2:0]
  output logic                              m_axis_tlast,
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [arx_pkg::CNT_W-1:0]         cfg_wdata_i
);

  // Raw configuration registers; the datapath only sees the clamped counts.
  arx_pkg::cnt_t     num_outputs_q, num_inputs_q, order_a_q, order_b_q;
  arx_pkg::arx_cfg_t cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_outputs_q <= arx_pkg::cnt_t'(1);
      num_inputs_q  <= arx_pkg::cnt_t'(1);
      order_a_q     <= arx_pkg::cnt_t'(1);
      order_b_q     <= arx_pkg::cnt_t'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        arx_pkg::REG_NUM_OUTPUTS: num_outputs_q <= cfg_wdata_i;
        arx_pkg::REG_NUM_INPUTS:  num_inputs_q  <= cfg_wdata_i;
        arx_pkg::REG_ORDER_A:     order_a_q     <= cfg_wdata_i;
        arx_pkg::REG_ORDER_B:     order_b_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A count of zero acts as one and anything above the maximum acts as the maximum.
  always_comb begin
    cfg.no = arx_pkg::eff_count(num_outputs_q, arx_pkg::EFF_OUT_MAX);
    cfg.ni = arx_pkg::eff_count(num_inputs_q, arx_pkg::EFF_IN_MAX);
    cfg.pa = arx_pkg::eff_count(order_a_q, arx_pkg::EFF_A_MAX);
    cfg.pb = arx_pkg::eff_count(order_b_q, arx_pkg::EFF_B_MAX);
  end

  // Input transaction fields.
  arx_pkg::idx_t                      in_index;
  logic signed [arx_pkg::SMP_W-1:0]   in_sample;
  logic                               in_accept;
  logic                               commit;

  assign in_index  = s_axis_tdata[9:0];
  assign in_sample = s_axis_tdata[41:10];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // A last input element commits the staged vectors even when its own channel is out of
  // range.
  assign commit = in_accept && (s_axis_tuser == arx_pkg::MODE_INPUT) && s_axis_tlast;

  arx_pkg::arx_ctrl_t ctrl;
  logic               mac_busy;
  logic               out_free;

  arx_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .commit_i   (commit),
    .mac_busy_i (mac_busy),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign s_axis_tready = ctrl.in_ready;

  // Staging registers for the vectors of the sample in progress. They keep their contents
  // across commits, so a channel not rewritten carries its old value forward.
  logic signed [arx_pkg::SMP_W-1:0] out_stage_q [arx_pkg::MAX_OUTPUTS];
  logic signed [arx_pkg::SMP_W-1:0] in_stage_q  [arx_pkg::MAX_INPUTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < arx_pkg::MAX_OUTPUTS; n++) begin
        out_stage_q[n] <= '0;
      end
      for (int n = 0; n < arx_pkg::MAX_INPUTS; n++) begin
        in_stage_q[n] <= '0;
      end
    end else if (in_accept) begin
      case (s_axis_tuser)
        arx_pkg::MODE_OUTPUT: begin
          if (in_index < arx_pkg::idx_t'(arx_pkg::MAX_OUTPUTS)) begin
            out_stage_q[arx_pkg::stg_out_idx_t'(in_index)] <= in_sample;
          end
        end
        arx_pkg::MODE_INPUT: begin
          if (in_index < arx_pkg::idx_t'(arx_pkg::MAX_INPUTS)) begin
            in_stage_q[arx_pkg::stg_in_idx_t'(in_index)] <= in_sample;
          end
        end
        default: ;
      endcase
    end
  end

  // Coefficient store: written by the clearing pass or by a coefficient transaction.
  logic                       coef_we;
  arx_pkg::coef_addr_t        coef_waddr;
  logic [arx_pkg::SMP_W-1:0]  coef_wdata;
  logic signed [arx_pkg::SMP_W-1:0] coef_rdata;

  assign coef_we    = ctrl.clr || (in_accept && s_axis_tuser == arx_pkg::MODE_COEF);
  assign coef_waddr = ctrl.clr ? ctrl.clr_addr : in_index;
  assign coef_wdata = ctrl.clr ? '0 : in_sample;

  arx_ram #(
    .WIDTH (arx_pkg::SMP_W),
    .DEPTH (arx_pkg::COEF_DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (ctrl.coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Output and input histories: a commit copies the staged vectors into the newest slot.
  logic                              hout_we, hin_we;
  arx_pkg::hist_out_addr_t           hout_waddr;
  arx_pkg::hist_in_addr_t            hin_waddr;
  logic [arx_pkg::SMP_W-1:0]         hout_wdata, hin_wdata;
  logic signed [arx_pkg::SMP_W-1:0]  hout_rdata, hin_rdata;

  assign hout_we    = ctrl.clr || ctrl.cmt_we_out;
  assign hout_waddr = ctrl.clr ? ctrl.clr_addr[arx_pkg::HIST_OUT_AW-1:0] : ctrl.cmt_out_addr;
  assign hout_wdata = ctrl.clr ? '0 : out_stage_q[arx_pkg::stg_out_idx_t'(ctrl.cmt_idx)];
  assign hin_we     = ctrl.clr || ctrl.cmt_we_in;
  assign hin_waddr  = ctrl.clr ? ctrl.clr_addr[arx_pkg::HIST_IN_AW-1:0] : ctrl.cmt_in_addr;
  assign hin_wdata  = ctrl.clr ? '0 : in_stage_q[arx_pkg::stg_in_idx_t'(ctrl.cmt_idx)];

  arx_ram #(
    .WIDTH (arx_pkg::SMP_W),
    .DEPTH (arx_pkg::HIST_OUT_DEPTH)
  ) u_hout_ram (
    .clk_i   (clk_i),
    .we_i    (hout_we),
    .waddr_i (hout_waddr),
    .wdata_i (hout_wdata),
    .raddr_i (ctrl.out_raddr),
    .rdata_o (hout_rdata)
  );

  arx_ram #(
    .WIDTH (arx_pkg::SMP_W),
    .DEPTH (arx_pkg::HIST_IN_DEPTH)
  ) u_hin_ram (
    .clk_i   (clk_i),
    .we_i    (hin_we),
    .waddr_i (hin_waddr),
    .wdata_i (hin_wdata),
    .raddr_i (ctrl.in_raddr),
    .rdata_o (hin_rdata)
  );

  // The shared multiply-accumulate unit. Terms arrive in the order alpha (block rising,
  // then column rising) followed by beta, which fixes where the accumulator saturates.
  logic signed [arx_pkg::ACC_W-1:0] acc;

  arx_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (ctrl.rd_en),
    .beta_i      (ctrl.rd_beta),
    .acc_clear_i (ctrl.acc_clear),
    .coef_i      (coef_rdata),
    .out_smp_i   (hout_rdata),
    .in_smp_i    (hin_rdata),
    .acc_o       (acc),
    .busy_o      (mac_busy)
  );

  // Result register. It frees up in the same cycle that its transaction completes, so a
  // waiting result moves in without a bubble.
  logic                       m_valid_q;
  logic [arx_pkg::SMP_W-1:0]  m_data_q;
  arx_pkg::sel_t              m_chan_q;
  logic                       m_last_q;

  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      m_data_q <= arx_pkg::to_q16(acc);
      m_chan_q <= ctrl.emit_chan;
      m_last_q <= ctrl.emit_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_chan_q;
  assign m_axis_tlast  = m_last_q;

endmodule

### hdl/arx_checker.sv
`timescale 1ns / 1ps

module arx_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [arx_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [arx_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  logic [arx_pkg::SEL_W-1:0]         m_axis_tuser,
  input  logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [arx_pkg::CNT_W-1:0]         cfg_wdata_i
);

  logic in_acc;
  logic commit;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign commit = in_acc && (s_axis_tuser == arx_pkg::MODE_INPUT) && s_axis_tlast;

  // A pending result holds its value until it is taken.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("pending result changed before it was taken");

  // The final input element of a sample starts the computation and closes the input.
  a_commit_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> !s_axis_tready)
    else $error("input still open after a committing transaction");

  // Any other transaction leaves the input ready for the next one.
  a_plain_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !commit |=> s_axis_tready)
    else $error("input stalled after a non-committing transaction");

  // A new result only appears at the end of a computation, never out of the idle state.
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while the controller was idle");

endmodule

bind mimo_arx_controller arx_checker u_arx_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import arx_pkg::*;

  // The bench clock and its reset.
  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 7;

  // Mode 3 has no meaning to the block, so the package gives it no name.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Coefficient address layout: alpha rows start at zero, beta rows in the upper half.
  localparam int ROW_STRIDE = ADDR_SPAN * ADDR_SPAN;
  localparam int BETA_BASE  = COEF_DEPTH / 2;

  // Q16.16 saturation bounds, held in 64 bits for comparison with the rounded sum.
  localparam longint Q16_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q16_MIN = -Q16_MAX - 1;

  // A generous settling pause covers the items with no result before the configuration
  // is touched again.
  localparam int SETTLE_CYCLES = 64;

  // The long hold on the result port during the pressure phase.
  localparam int HOLD_CYCLES = 500;

  // Stopping point of the random part.
  localparam int RANDOM_ITEMS        = 250;
  localparam int MIN_RANDOM_CONTROLS = 48;

  // At the largest configuration the receiver can stall for most of a worst-case sample.
  // A few hundred samples at that cost, plus the clearing pass after reset, still fit
  // several times into this limit.
  localparam longint TIMEOUT_NS = 40_000_000;

  // Cap on printed mismatches, so that a badly broken block does not flood the log.
  localparam int REPORT_CAP = 100;

  // One input transaction as the bench sees it.
  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  index;
    logic [SMP_W-1:0]  value;
    logic              last;
  } arx_item_t;

  // One control output: value, channel and end-of-run flag.
  typedef struct packed {
    logic [SMP_W-1:0]  value;
    sel_t              chan;
    logic              last;
  } ctrl_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // index[9:0], sample_value[41:10]
  logic [1:0]            s_axis_tuser = '0;   // mode[1:0]
  logic                  s_axis_tlast = 1'b0;

  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;        // control_value[31:0]
  logic [SEL_W-1:0]      m_axis_tuser;        // channel[2:0]
  logic                  m_axis_tlast;

  logic                  cfg_we_i = 1'b0;
  logic [1:0]            cfg_idx_i = REG_NUM_OUTPUTS;
  cnt_t                  cfg_wdata_i = '0;

  mimo_arx_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Control-law predictor. It keeps its own copy of the coefficient store, the staging
  // vectors, both circular histories and the register values as last written.
  // ---------------------------------------------------------------------------------------
  logic signed [SMP_W-1:0] coef_mem [COEF_DEPTH];
  logic signed [SMP_W-1:0] y_hist   [HIST_OUT_DEPTH];
  logic signed [SMP_W-1:0] u_hist   [HIST_IN_DEPTH];
  logic signed [SMP_W-1:0] y_stage  [MAX_OUTPUTS];
  logic signed [SMP_W-1:0] u_stage  [MAX_INPUTS];
  int                      y_newest;
  int                      u_newest;
  cnt_t                    reg_no, reg_ni, reg_pa, reg_pb;

  // Control values still owed by the block, oldest first.
  ctrl_result_t            expected_controls [$];

  // Register values outside 1..max act as the nearest bound.
  function automatic int fit_count(input cnt_t v, input cnt_t top);
    if (v == '0) begin
      return 1;
    end
    return (v > top) ? int'(top) : int'(v);
  endfunction

  // The newest slot moves back one place; outside the order it wraps to the oldest slot.
  function automatic int back_one(input int slot, input int order);
    return (slot == 0 || slot >= order) ? order - 1 : slot - 1;
  endfunction

  // 64-bit addition clamped to the signed range, done one bit wider.
  function automatic longint sat_sum(input longint a, input longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return s[63:0];
  endfunction

  // Q24.40 down to Q16.16: drop 24 fraction bits, ties go toward plus infinity.
  function automatic logic [SMP_W-1:0] round_q16(input longint acc);
    longint q;
    q = (acc >>> 24) + longint'(acc[23]);
    if (q > Q16_MAX) begin
      return Q16_MAX[SMP_W-1:0];
    end
    if (q < Q16_MIN) begin
      return Q16_MIN[SMP_W-1:0];
    end
    return q[SMP_W-1:0];
  endfunction

  // Applies one accepted transaction to the predicted state. A last input element commits
  // both staged vectors and queues one control value per input channel.
  task automatic apply_arx_item(input arx_item_t it);
    int           no, ni, pa, pb, slot;
    longint       acc;
    ctrl_result_t r;
    case (it.mode)
      MODE_COEF: begin
        coef_mem[it.index] = it.value;
      end
      MODE_OUTPUT: begin
        if (it.index < MAX_OUTPUTS) y_stage[it.index] = it.value;
      end
      MODE_INPUT: begin
        if (it.index < MAX_INPUTS) u_stage[it.index] = it.value;
      end
      default: ;
    endcase
    if (it.mode != MODE_INPUT || !it.last) return;

    no = fit_count(reg_no, EFF_OUT_MAX);
    ni = fit_count(reg_ni, EFF_IN_MAX);
    pa = fit_count(reg_pa, EFF_A_MAX);
    pb = fit_count(reg_pb, EFF_B_MAX);

    // Only the channels in use are copied; the stages themselves keep their contents.
    y_newest = back_one(y_newest, pa);
    for (int j = 0; j < no; j++) y_hist[y_newest * MAX_OUTPUTS + j] = y_stage[j];
    u_newest = back_one(u_newest, pb);
    for (int j = 0; j < ni; j++) u_hist[u_newest * MAX_INPUTS + j] = u_stage[j];

    // Alpha terms first, then beta terms, each with the age outer and the column inner.
    for (int i = 0; i < ni; i++) begin
      acc = 0;
      for (int k = 0; k < pa; k++) begin
        slot = (y_newest + k) % pa;
        for (int j = 0; j < no; j++) begin
          acc = sat_sum(acc, longint'(coef_mem[i * ROW_STRIDE + k * ADDR_SPAN + j]) *
                             longint'(y_hist[slot * MAX_OUTPUTS + j]));
        end
      end
      for (int k = 0; k < pb; k++) begin
        slot = (u_newest + k) % pb;
        for (int j = 0; j < ni; j++) begin
          acc = sat_sum(acc, longint'(coef_mem[BETA_BASE + i * ROW_STRIDE + k * ADDR_SPAN + j]) *
                             longint'(u_hist[slot * MAX_INPUTS + j]));
        end
      end
      r.value = round_q16(acc);
      r.chan  = sel_t'(i);
      r.last  = (i == ni - 1);
      expected_controls.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Input side. The stimulus block fills the feed queue; this driver offers the entries in
  // bursts of random length separated by random gaps when the phase allows them, and hands
  // every accepted transaction to the predictor at the edge where it is taken.
  // ---------------------------------------------------------------------------------------
  arx_item_t  feed_queue [$];
  arx_item_t  cur_item = '0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         tx_max_gap = 0;

  always @(posedge clk_i) begin : feed_driver
    logic offering;
    offering = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_arx_item(cur_item);
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (feed_queue.size() != 0) begin
          cur_item = feed_queue.pop_front();
          offering = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          burst_left--;
          // A gap follows the end of each burst, unless this phase runs without idling.
          if (burst_left == 0 && tx_max_gap != 0) gap_left = $urandom_range(0, tx_max_gap);
        end
      end
    end
    s_axis_tvalid <= offering;
    s_axis_tdata  <= {{(S_TDATA_W - IDX_W - SMP_W){1'b0}}, cur_item.value, cur_item.index};
    s_axis_tuser  <= cur_item.mode;
    s_axis_tlast  <= cur_item.last;
  end

  // ---------------------------------------------------------------------------------------
  // Result side. The receiver walks a 16-bit ready pattern chosen per phase. A new hold
  // token from the stimulus block makes it refuse every transaction until the hold count
  // loaded from HOLD_CYCLES runs out, while the sender keeps offering.
  // ---------------------------------------------------------------------------------------
  logic [15:0] rx_pattern = '1;
  logic [3:0]  rx_tick = '0;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 4'd1;
    if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_pattern[rx_tick];
    end
  end

  // Every accepted result is checked against the oldest control value still owed.
  int mismatches = 0;
  int controls_seen = 0;

  task automatic flag_mismatch(input string what, input logic [SMP_W-1:0] want,
                               input logic [SMP_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $error("%s: expected 0x%08h, actual 0x%08h", what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    ctrl_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      controls_seen++;
      if (expected_controls.size() == 0) begin
        flag_mismatch("unexpected result, control_value", '0, m_axis_tdata);
      end else begin
        want = expected_controls.pop_front();
        if (m_axis_tdata !== want.value) begin
          flag_mismatch("control_value", want.value, m_axis_tdata);
        end
        if (m_axis_tuser !== want.chan) begin
          flag_mismatch("channel", SMP_W'(want.chan), SMP_W'(m_axis_tuser));
        end
        if (m_axis_tlast !== want.last) begin
          flag_mismatch("last_of_run", SMP_W'(want.last), SMP_W'(m_axis_tlast));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers. The effective counts below steer the generated samples and
  // coefficient addresses toward the part of the store that the current setting reads.
  // ---------------------------------------------------------------------------------------
  int eff_no = 1, eff_ni = 1, eff_pa = 1, eff_pb = 1;
  int fed_count = 0;

  // Queues one transaction. Items that the block simply drops are not counted.
  task automatic feed(input logic [1:0] mode, input logic [IDX_W-1:0] idx,
                      input logic [SMP_W-1:0] val, input logic last);
    arx_item_t it;
    it.mode  = mode;
    it.index = idx;
    it.value = val;
    it.last  = last;
    feed_queue.push_back(it);
    if (mode == MODE_COEF || (mode != MODE_UNUSED && idx < MAX_OUTPUTS)) fed_count++;
  endtask

  // Q16.16 samples: mostly within about +-8.0 so results stay readable, with full-range
  // values and the extremes mixed in to drive the saturation paths.
  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  // Q8.24 coefficients: mostly within about +-2.0, otherwise full range or extremes.
  function automatic logic [SMP_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000;
    endcase
  endfunction

  // Mostly an address that the current setting reads, sometimes anywhere in the store.
  function automatic logic [IDX_W-1:0] rand_coef_addr();
    int row;
    row = $urandom_range(0, eff_ni - 1);
    if ($urandom_range(0, 4) == 0) begin
      return $urandom_range(0, COEF_DEPTH - 1);
    end
    if ($urandom_range(0, 1) == 0) begin
      return IDX_W'(row * ROW_STRIDE + $urandom_range(0, eff_pa - 1) * ADDR_SPAN +
                    $urandom_range(0, eff_no - 1));
    end
    return IDX_W'(BETA_BASE + row * ROW_STRIDE + $urandom_range(0, eff_pb - 1) * ADDR_SPAN +
                  $urandom_range(0, eff_ni - 1));
  endfunction

  // A well-formed sample: every output element in use, then every input element, the
  // last one flagged. A flag on an output element is noise the block must ignore.
  task automatic queue_sample();
    for (int j = 0; j < eff_no; j++) begin
      feed(MODE_OUTPUT, IDX_W'(j), rand_sample(), $urandom_range(0, 7) == 0);
    end
    for (int j = 0; j < eff_ni; j++) begin
      feed(MODE_INPUT, IDX_W'(j), rand_sample(), j == eff_ni - 1);
    end
  endtask

  // Broken or meaningless transactions between samples.
  task automatic queue_noise();
    case ($urandom_range(0, 4))
      0: feed(MODE_UNUSED, $urandom_range(0, COEF_DEPTH - 1), $urandom, $urandom_range(0, 1));
      1: feed(MODE_OUTPUT, $urandom_range(MAX_OUTPUTS, COEF_DEPTH - 1), $urandom,
              $urandom_range(0, 1));
      // An input element beyond the stage still commits the sample when flagged last.
      2: feed(MODE_INPUT, $urandom_range(MAX_INPUTS, COEF_DEPTH - 1), $urandom,
              $urandom_range(0, 1));
      // A commit after partial staging reuses the stale stage contents.
      3: feed(MODE_INPUT, $urandom_range(0, MAX_INPUTS - 1), rand_sample(), 1'b1);
      default: feed(MODE_INPUT, $urandom_range(0, MAX_INPUTS - 1), rand_sample(), 1'b0);
    endcase
  endtask

  task automatic queue_phase(input int n_samples, input int n_coefs);
    repeat (n_coefs) feed(MODE_COEF, rand_coef_addr(), rand_coef(), $urandom_range(0, 1));
    repeat (n_samples) begin
      repeat ($urandom_range(0, 2)) begin
        feed(MODE_COEF, rand_coef_addr(), rand_coef(), $urandom_range(0, 1));
      end
      if ($urandom_range(0, 5) == 0) queue_noise();
      queue_sample();
    end
  endtask

  function automatic cnt_t pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return cnt_t'($urandom_range(9, 15));
      2: return cnt_t'(8);
      default: return cnt_t'($urandom_range(1, 4));
    endcase
  endfunction

  // Writes all four registers on consecutive edges. The block is idle whenever this runs.
  task automatic set_config(input cnt_t no, input cnt_t ni, input cnt_t pa, input cnt_t pb);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_NUM_OUTPUTS;
    cfg_wdata_i <= no;
    @(posedge clk_i);
    cfg_idx_i   <= REG_NUM_INPUTS;
    cfg_wdata_i <= ni;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ORDER_A;
    cfg_wdata_i <= pa;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ORDER_B;
    cfg_wdata_i <= pb;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reg_no = no;
    reg_ni = ni;
    reg_pa = pa;
    reg_pb = pb;
    eff_no = fit_count(no, EFF_OUT_MAX);
    eff_ni = fit_count(ni, EFF_IN_MAX);
    eff_pa = fit_count(pa, EFF_A_MAX);
    eff_pb = fit_count(pb, EFF_B_MAX);
  endtask

  // Waits until every queued item is taken and every control value has arrived, then
  // lets the block settle. Checked between edges so that no edge activity is raced.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (feed_queue.size() != 0 || s_axis_tvalid || expected_controls.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Per-phase idling: sometimes none at all on either side.
  task automatic pick_idling(input bit no_tx_gaps);
    tx_max_gap = (no_tx_gaps || $urandom_range(0, 2) == 0) ? 0 :
                 ($urandom_range(0, 1) ? 3 : 12);
    case ($urandom_range(0, 3))
      0: rx_pattern = '1;
      1: rx_pattern = 16'($urandom) | 16'h0001;
      2: rx_pattern = 16'($urandom | $urandom) | 16'h0001;
      default: rx_pattern = 16'($urandom & $urandom) | 16'h0001;
    endcase
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    for (int n = 0; n < COEF_DEPTH; n++) coef_mem[n] = '0;
    for (int n = 0; n < HIST_OUT_DEPTH; n++) y_hist[n] = '0;
    for (int n = 0; n < HIST_IN_DEPTH; n++) u_hist[n] = '0;
    for (int n = 0; n < MAX_OUTPUTS; n++) y_stage[n] = '0;
    for (int n = 0; n < MAX_INPUTS; n++) u_stage[n] = '0;
    y_newest = 0;
    u_newest = 0;
    reg_no = cnt_t'(1);
    reg_ni = cnt_t'(1);
    reg_pa = cnt_t'(1);
    reg_pb = cnt_t'(1);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset setting of one output, one input and order one. The
    // block is still clearing its stores, so the driver simply waits for tready.
    @(negedge clk_i);
    pick_idling(1'b0);
    // A coefficient of 2^-24 times half of that step lands exactly on a rounding tie,
    // once positive (rounds up to one LSB) and once negative (rounds up to zero).
    feed(MODE_COEF,   10'd0,     32'h0000_0001, 1'b0);
    feed(MODE_OUTPUT, 10'd0,     32'h0080_0000, 1'b0);
    feed(MODE_INPUT,  10'd0,     32'h0000_0000, 1'b1);
    feed(MODE_OUTPUT, 10'd0,     32'hFF80_0000, 1'b1);
    feed(MODE_INPUT,  10'd0,     32'h0000_0000, 1'b1);
    // Most negative coefficients and samples: two products of +2^62 overflow the
    // accumulator, which must clamp, then the output clamps to the positive limit.
    feed(MODE_COEF,   10'd0,     32'h8000_0000, 1'b1);
    feed(MODE_COEF,   10'd512,   32'h8000_0000, 1'b0);
    feed(MODE_OUTPUT, 10'd0,     32'h8000_0000, 1'b0);
    feed(MODE_INPUT,  10'd0,     32'h8000_0000, 1'b1);
    // Largest positive samples against those coefficients clamp to the negative limit.
    feed(MODE_OUTPUT, 10'd0,     32'h7FFF_FFFF, 1'b0);
    feed(MODE_INPUT,  10'd0,     32'h7FFF_FFFF, 1'b1);
    // Ignored mode, out-of-range channels, and a commit from an out-of-range element.
    feed(MODE_UNUSED, 10'h3FF,   32'hFFFF_FFFF, 1'b1);
    feed(MODE_OUTPUT, 10'h3FF,   32'h1234_5678, 1'b0);
    feed(MODE_INPUT,  10'h200,   32'h0001_0000, 1'b1);
    // Top of the coefficient store, then gains of +1.0 and -1.0: 3.0 - 1.5 = 1.5.
    feed(MODE_COEF,   10'h3FF,   32'h7FFF_FFFF, 1'b0);
    feed(MODE_COEF,   10'd0,     32'h0100_0000, 1'b0);
    feed(MODE_COEF,   10'd512,   32'hFF00_0000, 1'b0);
    feed(MODE_OUTPUT, 10'd0,     32'h0003_0000, 1'b0);
    feed(MODE_INPUT,  10'd0,     32'h0001_0000, 1'b0);
    feed(MODE_INPUT,  10'd0,     32'h0001_8000, 1'b1);
    wait_idle();

    // Random part, one setting per phase. The first phases take the extremes: everything
    // at eight, then zeros and fifteens that must act as one and eight. Phase 3 is the
    // pressure phase, where the result port holds off while samples keep coming.
    fed_count = 0;
    phase = 0;
    while (fed_count < RANDOM_ITEMS || controls_seen < MIN_RANDOM_CONTROLS) begin
      case (phase)
        0: set_config(4'd8, 4'd8, 4'd8, 4'd8);
        1: set_config(4'd0, 4'd15, 4'd0, 4'd15);
        2: set_config(4'd15, 4'd0, 4'd15, 4'd0);
        3: set_config(4'd2, 4'd3, 4'd2, 4'd2);
        default: set_config(pick_count(), pick_count(), pick_count(), pick_count());
      endcase
      if (phase == 3) begin
        @(posedge clk_i);
        hold_token <= hold_token + 1;
      end
      @(negedge clk_i);
      pick_idling(phase == 3);
      case (phase)
        0: queue_phase(2, 24);
        1, 2: queue_phase(2, 16);
        3: queue_phase(8, 4);
        default: queue_phase($urandom_range(3, 7), $urandom_range(2, 10));
      endcase
      wait_idle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
